// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NWAS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define NWAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/nwas_pkg.sv =====
// ----------------------------------------------------------------------------
// nwas_pkg
// Types, constants and cost functions of the nested word alignment scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package nwas_pkg;

  localparam int NUM_WORDS  = 16;
  localparam int WORD_LEN   = 32;
  localparam int CHAR_DEPTH = 256;
  localparam int CHAR_AW    = 8;
  localparam int CNT_W      = 9;
  localparam int WC_W       = 5;
  localparam int LEN_W      = 6;
  localparam int SW         = 15;
  localparam int IW         = 12;
  localparam int IROW_DEPTH = WORD_LEN + 1;

  localparam logic [2:0] CMD_TARGET_CHAR  = 3'd0;
  localparam logic [2:0] CMD_TEXT_CHAR    = 3'd1;
  localparam logic [2:0] CMD_CLOSE_TARGET = 3'd2;
  localparam logic [2:0] CMD_CLOSE_TEXT   = 3'd3;
  localparam logic [2:0] CMD_COMPUTE      = 3'd4;

  localparam logic [1:0] MODE_POPCOUNT = 2'd0;
  localparam logic [1:0] MODE_NIBBLE   = 2'd1;

  typedef struct packed {
    logic load;
    logic start;
    logic oinit_step;
    logic orow_start;
    logic ocell_start;
    logic iinit_step;
    logic irow_read;
    logic irow_start;
    logic icell_read;
    logic icell_calc;
    logic oupd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic oj_at_end;
    logic oi_at_end;
    logic ij_at_xn;
    logic ii_at_tn;
    logic out_free;
  } stat_t;

  function automatic logic [3:0] pop8(input logic [7:0] x);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + {3'b0, x[i]};
    return n;
  endfunction

  function automatic logic [2:0] letter_cost(input logic [1:0] mode, input logic [7:0] x);
    logic [3:0] p;
    logic [2:0] d;
    p = pop8(x);
    d = '0;
    unique case (mode)
      MODE_POPCOUNT: d = p[2:0] | {3{p[3]}};
      MODE_NIBBLE: begin
        for (int k = 0; k < 2; k++) begin
          if (pop8({4'b0, x[4*k +: 4]}) == 4'd1) d = d + 3'd3;
          else if (x[4*k +: 4] == 4'd0) d = d + 3'd1;
        end
      end
      default: begin
        if (p <= 4'd2) d = p[2:0];
        else if (p == 4'd3) d = 3'd6;
        else d = 3'd3;
      end
    endcase
    return d;
  endfunction

  // popcount 8 only occurs when x is all ones; letter_cost saturates it to 7
  // because p[3] set means p == 8, so pop_cost returns pop8 directly in that mode
  function automatic logic [3:0] pop_cost(input logic [1:0] mode, input logic [7:0] x);
    if (mode == MODE_POPCOUNT) return pop8(x);
    return {1'b0, letter_cost(mode, x)};
  endfunction

  function automatic logic [12:0] times_gap(input logic [8:0] n);
    return ({4'b0, n} << 3) + ({4'b0, n} << 1);
  endfunction

  function automatic logic signed [SW-1:0] max3(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b,
                                                 input logic signed [SW-1:0] c);
    logic signed [SW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nwas_ram.sv =====
// ----------------------------------------------------------------------------
// nwas_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nwas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nwas_ctrl.sv =====
// ----------------------------------------------------------------------------
// nwas_ctrl
// Sequencer: request intake, outer and inner alignment loops, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module nwas_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire logic [2:0]      req_command,
  output logic                 req_ready,
  input  wire nwas_pkg::stat_t stat,
  output nwas_pkg::cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_OINIT = 11'b00000000010,
    S_OROW  = 11'b00000000100,
    S_OCELL = 11'b00000001000,
    S_IINIT = 11'b00000010000,
    S_IROW  = 11'b00000100000,
    S_IROW2 = 11'b00001000000,
    S_ICELL = 11'b00010000000,
    S_ICALC = 11'b00100000000,
    S_OUPD  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_command == nwas_pkg::CMD_COMPUTE) begin
            cmd.start = 1'b1;
            state_next = S_OINIT;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_OINIT: begin
        if (stat.oj_at_end) state_next = S_OROW;
        else cmd.oinit_step = 1'b1;
      end
      S_OROW: begin
        if (stat.oi_at_end) begin
          state_next = S_DONE;
        end else begin
          cmd.orow_start = 1'b1;
          state_next = S_OCELL;
        end
      end
      S_OCELL: begin
        if (stat.oj_at_end) begin
          state_next = S_OROW;
        end else begin
          cmd.ocell_start = 1'b1;
          state_next = S_IINIT;
        end
      end
      S_IINIT: begin
        cmd.iinit_step = 1'b1;
        if (stat.ij_at_xn) state_next = S_IROW;
      end
      S_IROW: begin
        if (stat.ii_at_tn) begin
          state_next = S_OUPD;
        end else begin
          cmd.irow_read = 1'b1;
          state_next = S_IROW2;
        end
      end
      S_IROW2: begin
        cmd.irow_start = 1'b1;
        state_next = S_ICELL;
      end
      S_ICELL: begin
        if (stat.ij_at_xn) begin
          state_next = S_IROW;
        end else begin
          cmd.icell_read = 1'b1;
          state_next = S_ICALC;
        end
      end
      S_ICALC: begin
        cmd.icell_calc = 1'b1;
        state_next = S_ICELL;
      end
      S_OUPD: begin
        cmd.oupd = 1'b1;
        state_next = S_OCELL;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nwas_datapath.sv =====
// ----------------------------------------------------------------------------
// nwas_datapath
// Character and word stores, score rows, cell arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nwas_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_wr_data,
  input  wire logic [2:0]      req_command,
  input  wire logic [7:0]      req_char,
  input  wire nwas_pkg::cmd_t  cmd,
  output nwas_pkg::stat_t      stat,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [15:0]          m_tdata
);

  localparam int SW = nwas_pkg::SW;
  localparam int IW = nwas_pkg::IW;
  localparam int IAW = $clog2(nwas_pkg::IROW_DEPTH);

  logic [1:0] mode;
  logic [8:0] tcnt, xcnt, topen, xopen;
  logic [4:0] twc, xwc;
  logic       ovf;

  logic [8:0] tstart [nwas_pkg::NUM_WORDS];
  logic [8:0] xstart [nwas_pkg::NUM_WORDS];
  logic [5:0] tlen   [nwas_pkg::NUM_WORDS];
  logic [5:0] xlen   [nwas_pkg::NUM_WORDS];

  logic [4:0] oi, oj;
  logic signed [SW-1:0] odiag, oleft, oup;
  logic signed [SW-1:0] orow [nwas_pkg::NUM_WORDS + 1];
  logic [8:0] ots, cur_xs;
  logic [5:0] otn, cur_xn;

  logic [5:0] ii, ij;
  logic signed [IW-1:0] idiag, ileft;
  logic [7:0] tc;

  logic [7:0] tram_q, xram_q;
  logic [IW-1:0] irow_q;

  // load decode
  logic t_app, x_app, t_cls, x_cls, t_full, x_full;
  assign t_full = tcnt[8] | twc[4] | ((tcnt - topen) >= 9'd32);
  assign x_full = xcnt[8] | xwc[4] | ((xcnt - xopen) >= 9'd32);
  assign t_app = cmd.load && (req_command == nwas_pkg::CMD_TARGET_CHAR);
  assign x_app = cmd.load && (req_command == nwas_pkg::CMD_TEXT_CHAR);
  assign t_cls = cmd.load && (req_command == nwas_pkg::CMD_CLOSE_TARGET);
  assign x_cls = cmd.load && (req_command == nwas_pkg::CMD_CLOSE_TEXT);

  always_ff @(posedge clk) begin
    if (rst) mode <= nwas_pkg::MODE_POPCOUNT;
    else if (cfg_wr_en) mode <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      tcnt <= '0; xcnt <= '0; topen <= '0; xopen <= '0;
      twc <= '0; xwc <= '0; ovf <= 1'b0;
    end else begin
      if (t_app) begin
        if (t_full) ovf <= 1'b1;
        else tcnt <= tcnt + 9'd1;
      end
      if (x_app) begin
        if (x_full) ovf <= 1'b1;
        else xcnt <= xcnt + 9'd1;
      end
      if (t_cls) begin
        if (twc[4]) begin
          ovf <= 1'b1;
        end else begin
          twc <= twc + 5'd1;
          topen <= tcnt;
        end
      end
      if (x_cls) begin
        if (xwc[4]) begin
          ovf <= 1'b1;
        end else begin
          xwc <= xwc + 5'd1;
          xopen <= xcnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t_cls && !twc[4]) begin
      tstart[twc[3:0]] <= topen;
      tlen[twc[3:0]]   <= 6'(tcnt - topen);
    end
    if (x_cls && !xwc[4]) begin
      xstart[xwc[3:0]] <= xopen;
      xlen[xwc[3:0]]   <= 6'(xcnt - xopen);
    end
  end

  // score arithmetic
  logic signed [SW-1:0] g_xl, g_tl, g_otn, g_xn, oinit_val, orow0_val, ocell_val;
  logic signed [SW-1:0] ws_ext;
  assign g_xl  = $signed({2'b0, nwas_pkg::times_gap({3'b0, xlen[oj[3:0]]})});
  assign g_tl  = $signed({2'b0, nwas_pkg::times_gap({3'b0, tlen[oi[3:0]]})});
  assign g_otn = $signed({2'b0, nwas_pkg::times_gap({3'b0, otn})});
  assign g_xn  = $signed({2'b0, nwas_pkg::times_gap({3'b0, cur_xn})});
  assign oinit_val = oleft - g_xl;
  assign orow0_val = orow[0] - g_tl;
  assign ws_ext = {{(SW-IW){ileft[IW-1]}}, ileft};
  assign ocell_val = nwas_pkg::max3(oup - g_otn, oleft - g_xn, odiag + ws_ext);

  logic [5:0] ii_inc;
  logic [12:0] g_ij, g_ii;
  logic signed [IW-1:0] iinit_val, irow0_val, icell_val, cost_ext;
  logic signed [SW-1:0] icell_wide;
  assign ii_inc = ii + 6'd1;
  assign g_ij = nwas_pkg::times_gap({3'b0, ij});
  assign g_ii = nwas_pkg::times_gap({3'b0, ii_inc});
  assign iinit_val = $signed(12'd0) - $signed({1'b0, g_ij[10:0]});
  assign irow0_val = $signed(12'd0) - $signed({1'b0, g_ii[10:0]});
  assign cost_ext = $signed({8'b0, nwas_pkg::pop_cost(mode, tc ^ xram_q)});
  assign icell_wide = nwas_pkg::max3(
      SW'($signed(irow_q)) - SW'(10),
      SW'(ileft) - SW'(10),
      SW'(idiag - cost_ext));
  assign icell_val = icell_wide[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      oj <= '0; oi <= '0; oleft <= '0; orow[0] <= '0;
    end
    if (cmd.oinit_step) begin
      orow[oj + 5'd1] <= oinit_val;
      oleft <= oinit_val;
      oj <= oj + 5'd1;
    end
    if (cmd.orow_start) begin
      ots <= tstart[oi[3:0]];
      otn <= tlen[oi[3:0]];
      odiag <= orow[0];
      orow[0] <= orow0_val;
      oleft <= orow0_val;
      oj <= '0;
      oi <= oi + 5'd1;
    end
    if (cmd.ocell_start) begin
      oup <= orow[oj + 5'd1];
      cur_xs <= xstart[oj[3:0]];
      cur_xn <= xlen[oj[3:0]];
      ii <= '0;
      ij <= '0;
    end
    if (cmd.iinit_step) begin
      ileft <= iinit_val;
      ij <= ij + 6'd1;
    end
    if (cmd.irow_start) begin
      tc <= tram_q;
      idiag <= $signed(irow_q);
      ileft <= irow0_val;
      ij <= '0;
      ii <= ii_inc;
    end
    if (cmd.icell_calc) begin
      ileft <= icell_val;
      idiag <= $signed(irow_q);
      ij <= ij + 6'd1;
    end
    if (cmd.oupd) begin
      orow[oj + 5'd1] <= ocell_val;
      oleft <= ocell_val;
      odiag <= oup;
      oj <= oj + 5'd1;
    end
  end

  // memories
  logic [8:0] t_raddr, x_raddr;
  logic [IAW-1:0] ir_raddr, ir_waddr;
  logic ir_we;
  logic [IW-1:0] ir_wdata;
  assign t_raddr = ots + {3'b0, ii};
  assign x_raddr = cur_xs + {3'b0, ij};
  assign ir_raddr = cmd.irow_read ? '0 : IAW'(ij + 6'd1);
  assign ir_we = cmd.iinit_step | cmd.irow_start | cmd.icell_calc;
  always_comb begin
    if (cmd.iinit_step) begin
      ir_waddr = IAW'(ij);
      ir_wdata = iinit_val;
    end else if (cmd.irow_start) begin
      ir_waddr = '0;
      ir_wdata = irow0_val;
    end else begin
      ir_waddr = IAW'(ij + 6'd1);
      ir_wdata = icell_val;
    end
  end

  nwas_ram #(.WIDTH(8), .DEPTH(nwas_pkg::CHAR_DEPTH)) u_tram (
    .clk(clk), .we(t_app && !t_full), .waddr(tcnt[7:0]), .wdata(req_char),
    .raddr(t_raddr[7:0]), .rdata(tram_q));

  nwas_ram #(.WIDTH(8), .DEPTH(nwas_pkg::CHAR_DEPTH)) u_xram (
    .clk(clk), .we(x_app && !x_full), .waddr(xcnt[7:0]), .wdata(req_char),
    .raddr(x_raddr[7:0]), .rdata(xram_q));

  nwas_ram #(.WIDTH(IW), .DEPTH(nwas_pkg::IROW_DEPTH)) u_irow (
    .clk(clk), .we(ir_we), .waddr(ir_waddr), .wdata(ir_wdata),
    .raddr(ir_raddr), .rdata(irow_q));

  assign stat.oj_at_end = (oj == xwc);
  assign stat.oi_at_end = (oi == twc);
  assign stat.ij_at_xn  = (ij == cur_xn);
  assign stat.ii_at_tn  = (ii == otn);
  assign stat.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.finish) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) m_tdata <= {1'b0, ovf, oleft[13:0]};
  end

  `NWAS_ASSERT_NEXT(a_clear_on_finish, clk, rst, cmd.finish,
      (tcnt == '0) && (xcnt == '0) && (twc == '0) && (xwc == '0) && !ovf,
      "stores not cleared after result")
  `NWAS_ASSERT_NOW(a_ovf_sticky, clk, rst, $fell(ovf),
      $past(cmd.finish) || $past(rst), "overflow flag dropped without a result")
  `NWAS_ASSERT_NOW(a_result_from_finish, clk, rst, $rose(m_tvalid),
      $past(cmd.finish), "result raised without finishing a compute")

endmodule

`default_nettype wire

// ===== hw/rtl/nested_word_alignment_score_unit.sv =====
// ----------------------------------------------------------------------------
// nested_word_alignment_score_unit
// Two-level global alignment score of a target word list against a text list.
// ----------------------------------------------------------------------------
// Load requests (characters, word closes) are accepted whenever the sequencer is
// idle. A compute request runs the outer word-list recurrence in a sequencer;
// each word pair runs an inner character alignment through one shared cell
// unit whose score row sits in a RAM with registered read. Each inner cell is
// a read state of the row RAM followed by a calculate-and-write state, and
// each inner row adds a read state and a start state. The result register
// loads once the last outer row is done and the result register is free.
// No request is taken during compute; the result register lets the next
// loads proceed while the score waits.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_word_alignment_score_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,   // distance_mode
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,       // [2:0] command, [10:3] char_value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata        // [13:0] score, [14] overflow
);

  nwas_pkg::cmd_t  cmd;
  nwas_pkg::stat_t stat;

  nwas_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(s_tvalid), .req_command(s_tdata[2:0]), .req_ready(s_tready),
    .stat(stat), .cmd(cmd));

  nwas_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req_command(s_tdata[2:0]), .req_char(s_tdata[10:3]),
    .cmd(cmd), .stat(stat),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

endmodule

`default_nettype wire

// ===== sim/nwas_checker.sv =====
// ----------------------------------------------------------------------------
// nwas_checker
// Watches the request, result and mode-write ports of the nested word
// alignment scorer, keeps its own copy of the word stores, predicts the score
// of each compute request and compares every result against the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module nwas_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,      // [2:0] command, [10:3] char_value
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,      // [13:0] score, [14] overflow
  output int               error_count,
  output int               pending,
  output int               score_count,
  output int               overflow_count
);

  typedef struct packed {
    logic signed [13:0] score;
    logic               overflow;
  } score_t;

  score_t      expected_scores[$];
  logic [1:0]  mode;
  logic [7:0]  tgt_chars[nwas_pkg::CHAR_DEPTH];
  logic [7:0]  txt_chars[nwas_pkg::CHAR_DEPTH];
  int          tgt_end[nwas_pkg::NUM_WORDS];
  int          txt_end[nwas_pkg::NUM_WORDS];
  int          tgt_nchars, txt_nchars, tgt_nwords, txt_nwords;
  logic        dropped;

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    error_count++;
  endtask

  function automatic int char_distance(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [3:0] nib;
    int         p, d;
    x = a ^ b;
    p = $countones(x);
    d = 0;
    if (mode == nwas_pkg::MODE_POPCOUNT) return p;
    if (mode == nwas_pkg::MODE_NIBBLE) begin
      for (int k = 0; k < 2; k++) begin
        nib = x[4*k +: 4];
        if ($countones(nib) == 1) d += 3;
        else if (nib == 4'd0) d += 1;
      end
      return d;
    end
    // byte barrier, also for the unused mode
    if (p <= 2) return p;
    if (p == 3) return 6;
    return 3;
  endfunction

  function automatic int best3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic int pair_score(input int ts, input int tn, input int xs, input int xn);
    int row[nwas_pkg::WORD_LEN+1];
    int diag, up;
    for (int j = 0; j <= xn; j++) row[j] = -10 * j;
    for (int i = 1; i <= tn; i++) begin
      diag = row[0];
      row[0] = -10 * i;
      for (int j = 1; j <= xn; j++) begin
        up = row[j];
        row[j] = best3(up - 10, row[j-1] - 10,
                       diag - char_distance(tgt_chars[ts+i-1], txt_chars[xs+j-1]));
        diag = up;
      end
    end
    return row[xn];
  endfunction

  function automatic int list_alignment();
    int row[nwas_pkg::NUM_WORDS+1];
    int ts, tn, xs, xn, diag, up;
    row[0] = 0;
    for (int j = 1; j <= txt_nwords; j++)
      row[j] = row[j-1] - 10 * (txt_end[j-1] - ((j > 1) ? txt_end[j-2] : 0));
    for (int i = 1; i <= tgt_nwords; i++) begin
      ts = (i > 1) ? tgt_end[i-2] : 0;
      tn = tgt_end[i-1] - ts;
      diag = row[0];
      row[0] = diag - 10 * tn;
      for (int j = 1; j <= txt_nwords; j++) begin
        xs = (j > 1) ? txt_end[j-2] : 0;
        xn = txt_end[j-1] - xs;
        up = row[j];
        row[j] = best3(up - 10 * tn, row[j-1] - 10 * xn, diag + pair_score(ts, tn, xs, xn));
        diag = up;
      end
    end
    return row[txt_nwords];
  endfunction

  always @(posedge clk) begin
    score_t got, want;
    int     start;
    if (rst) begin
      mode = nwas_pkg::MODE_POPCOUNT;
      tgt_nchars = 0; txt_nchars = 0; tgt_nwords = 0; txt_nwords = 0;
      dropped = 1'b0;
      expected_scores.delete();
      error_count = 0; score_count = 0; overflow_count = 0;
      pending = 0;
    end else begin
      if (cfg_wr_en) mode = cfg_wr_data;
      // results first: a result never belongs to a request taken on the same edge
      if (m_tvalid && m_tready) begin
        got.score = m_tdata[13:0];
        got.overflow = m_tdata[14];
        if (expected_scores.size() == 0) begin
          report("unexpected result, score", got.score, 0);
        end else begin
          want = expected_scores.pop_front();
          if (got.score !== want.score) report("score", got.score, want.score);
          if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tdata[2:0])
          nwas_pkg::CMD_TARGET_CHAR: begin
            start = (tgt_nwords > 0 && tgt_nwords <= nwas_pkg::NUM_WORDS) ?
                    tgt_end[tgt_nwords-1] : 0;
            if (tgt_nchars >= nwas_pkg::CHAR_DEPTH || tgt_nwords >= nwas_pkg::NUM_WORDS ||
                tgt_nchars - start >= nwas_pkg::WORD_LEN) dropped = 1'b1;
            else tgt_chars[tgt_nchars++] = s_tdata[10:3];
          end
          nwas_pkg::CMD_TEXT_CHAR: begin
            start = (txt_nwords > 0 && txt_nwords <= nwas_pkg::NUM_WORDS) ?
                    txt_end[txt_nwords-1] : 0;
            if (txt_nchars >= nwas_pkg::CHAR_DEPTH || txt_nwords >= nwas_pkg::NUM_WORDS ||
                txt_nchars - start >= nwas_pkg::WORD_LEN) dropped = 1'b1;
            else txt_chars[txt_nchars++] = s_tdata[10:3];
          end
          nwas_pkg::CMD_CLOSE_TARGET: begin
            if (tgt_nwords >= nwas_pkg::NUM_WORDS) dropped = 1'b1;
            else tgt_end[tgt_nwords++] = tgt_nchars;
          end
          nwas_pkg::CMD_CLOSE_TEXT: begin
            if (txt_nwords >= nwas_pkg::NUM_WORDS) dropped = 1'b1;
            else txt_end[txt_nwords++] = txt_nchars;
          end
          nwas_pkg::CMD_COMPUTE: begin
            want.score = 14'(list_alignment());
            want.overflow = dropped;
            expected_scores.insert(expected_scores.size(), want);
            score_count++;
            if (dropped) overflow_count++;
            tgt_nchars = 0; txt_nchars = 0; tgt_nwords = 0; txt_nwords = 0;
            dropped = 1'b0;
          end
          default: ;
        endcase
      end
      pending = expected_scores.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/nested_word_alignment_score_unit_tb.sv =====
// ----------------------------------------------------------------------------
// nested_word_alignment_score_unit_tb
// Drives word lists and compute requests into the scorer under every letter
// distance mode, with random gaps on the request side and random stalls on
// the result side; the checker predicts and compares each score.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_word_alignment_score_unit_tb;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  int          error_count, pending, score_count, overflow_count;
  int          cycles, requests_sent;
  bit          no_gaps, no_stalls;
  logic [7:0]  last_word[nwas_pkg::WORD_LEN];

  nested_word_alignment_score_unit dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  nwas_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .error_count(error_count), .pending(pending), .score_count(score_count),
    .overflow_count(overflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d scores outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int idle_length(input bit off);
    int r;
    r = $urandom_range(0, 99);
    if (off || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result-side back-pressure
  always @(negedge clk) begin
    int hold;
    if (rst) begin
      m_tready = 1'b1;
    end else begin
      hold = idle_length(no_stalls);
      if (hold > 0) begin
        m_tready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [7:0] ch);
    int gap;
    gap = idle_length(no_gaps);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {5'b0, ch, cmd};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_drained();
    cfg_wr_data = m;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_word(input logic [2:0] char_cmd, input logic [2:0] close_cmd,
                           input int len, input bit like_last);
    logic [7:0] ch;
    for (int k = 0; k < len; k++) begin
      ch = 8'($urandom);
      if (like_last && k < nwas_pkg::WORD_LEN) begin
        ch = last_word[k];
        if ($urandom_range(0, 2) == 0) ch = ch ^ (8'd1 << $urandom_range(0, 7));
      end
      if (char_cmd == nwas_pkg::CMD_TARGET_CHAR && k < nwas_pkg::WORD_LEN) last_word[k] = ch;
      send(char_cmd, ch);
    end
    send(close_cmd, 8'($urandom));
  endtask

  // one compute request over a random pair of word lists
  task automatic word_list_set(input bit huge);
    int nt, nx, len, r;
    r = $urandom_range(0, 99);
    if (huge) begin
      for (int w = 0; w < 8; w++) begin
        send_word(nwas_pkg::CMD_TARGET_CHAR, nwas_pkg::CMD_CLOSE_TARGET,
                  nwas_pkg::WORD_LEN, 1'b0);
        send_word(nwas_pkg::CMD_TEXT_CHAR, nwas_pkg::CMD_CLOSE_TEXT,
                  nwas_pkg::WORD_LEN, 1'b1);
      end
    end else if (r < 10) begin
      // noise, including the unused commands
      repeat ($urandom_range(1, 6)) send(3'($urandom_range(0, 7)), 8'($urandom));
    end else begin
      nt = (r < 14) ? $urandom_range(15, 18) : $urandom_range(0, 4);
      nx = (r > 95) ? $urandom_range(15, 18) : $urandom_range(0, 4);
      for (int w = 0; w < ((nt > nx) ? nt : nx); w++) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 5);
        if (w < nt) send_word(nwas_pkg::CMD_TARGET_CHAR, nwas_pkg::CMD_CLOSE_TARGET,
                              len, 1'b0);
        if (w < nx) send_word(nwas_pkg::CMD_TEXT_CHAR, nwas_pkg::CMD_CLOSE_TEXT,
                              $urandom_range(0, 1) ? len : $urandom_range(0, 5),
                              $urandom_range(0, 1));
      end
      if ($urandom_range(0, 7) == 0) send(nwas_pkg::CMD_TARGET_CHAR, 8'($urandom));
      if ($urandom_range(0, 7) == 0) send(nwas_pkg::CMD_TEXT_CHAR, 8'($urandom));
    end
    send(nwas_pkg::CMD_COMPUTE, 8'($urandom));
  endtask

  initial begin
    logic [1:0] phase_modes[7];
    phase_modes = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
    requests_sent = 0;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: empty lists, byte extremes, unused commands, empty words
    send(nwas_pkg::CMD_COMPUTE, 8'h00);
    send(nwas_pkg::CMD_TARGET_CHAR, 8'h00);
    send(nwas_pkg::CMD_CLOSE_TARGET, 8'hff);
    send(nwas_pkg::CMD_TEXT_CHAR, 8'hff);
    send(nwas_pkg::CMD_CLOSE_TEXT, 8'h00);
    send(3'd5, 8'hff);
    send(3'd6, 8'h55);
    send(3'd7, 8'haa);
    send(nwas_pkg::CMD_COMPUTE, 8'hff);
    send(nwas_pkg::CMD_CLOSE_TARGET, 8'h00);
    send(nwas_pkg::CMD_CLOSE_TEXT, 8'h00);
    send(nwas_pkg::CMD_TEXT_CHAR, 8'h5a);     // left open, ignored by compute
    send(nwas_pkg::CMD_COMPUTE, 8'h00);
    set_mode(2'd1);
    // identical words under the nibble barrier still cost
    send(nwas_pkg::CMD_TARGET_CHAR, 8'h41);
    send(nwas_pkg::CMD_CLOSE_TARGET, 8'h00);
    send(nwas_pkg::CMD_TEXT_CHAR, 8'h41);
    send(nwas_pkg::CMD_CLOSE_TEXT, 8'h00);
    send(nwas_pkg::CMD_COMPUTE, 8'h00);
    set_mode(2'd2);
    send(nwas_pkg::CMD_TARGET_CHAR, 8'h07);
    send(nwas_pkg::CMD_CLOSE_TARGET, 8'h00);
    send(nwas_pkg::CMD_TEXT_CHAR, 8'h00);
    send(nwas_pkg::CMD_CLOSE_TEXT, 8'h00);
    send(nwas_pkg::CMD_COMPUTE, 8'h00);

    for (int ph = 0; ph < 7; ph++) begin
      set_mode(phase_modes[ph]);
      no_gaps = (ph == 2);
      no_stalls = (ph == 2 || ph == 4);
      if (ph == 1) word_list_set(1'b1);
      repeat (3) word_list_set(1'b0);
      // hold off until every score is back, then carry on
      wait_drained();
      repeat (3) word_list_set(1'b0);
    end

    wait_drained();
    $display("Sent %0d requests over all four distance modes; checked %0d scores",
             requests_sent, score_count);
    $display("%0d of those scores carried the overflow flag", overflow_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== nested_word_alignment_score_unit.f =====
+incdir+hw/rtl
hw/rtl/nwas_pkg.sv
hw/rtl/nwas_ram.sv
hw/rtl/nwas_ctrl.sv
hw/rtl/nwas_datapath.sv
hw/rtl/nested_word_alignment_score_unit.sv
sim/nwas_checker.sv
sim/nested_word_alignment_score_unit_tb.sv
